/* design/ksvm_pkg.sv */
// ----------------------------------------------------------------------------
// ksvm_pkg
// shared types and codes for the split-group velocity moment accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package ksvm_pkg;

  localparam int NUM_GROUPS  = 3;
  localparam int NUM_COMP    = 3;
  localparam int NUM_MOMENTS = 11;
  localparam int NUM_ENTRIES = NUM_GROUPS * NUM_COMP;

  localparam int GRP_W = 2;
  localparam int MOM_W = 4;
  localparam int ENT_W = 4;
  localparam int VAL_W = 64;

  // lane pipeline depth: square, speed, split multiply, combine
  localparam int PIPE_D = 4;

  // item modes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // particle groups
  localparam logic [GRP_W-1:0] GRP_POS  = 2'd0;
  localparam logic [GRP_W-1:0] GRP_NEG  = 2'd1;
  localparam logic [GRP_W-1:0] GRP_FULL = 2'd2;

  // moment codes
  localparam logic [MOM_W-1:0] MOM_COUNT    = 4'd0;
  localparam logic [MOM_W-1:0] MOM_FIRST_X  = 4'd1;
  localparam logic [MOM_W-1:0] MOM_FIRST_Z  = 4'd3;
  localparam logic [MOM_W-1:0] MOM_SECOND_X = 4'd4;
  localparam logic [MOM_W-1:0] MOM_SECOND_Z = 4'd6;
  localparam logic [MOM_W-1:0] MOM_THIRD_X  = 4'd7;
  localparam logic [MOM_W-1:0] MOM_THIRD_Z  = 4'd9;
  localparam logic [MOM_W-1:0] MOM_TOTAL    = 4'd10;

  // accumulator control
  typedef struct packed {
    logic             add;
    logic [GRP_W-1:0] grp;
    logic             clr;
  } acc_ctl_t;

  // first entry of a group in the sum arrays
  function automatic logic [ENT_W-1:0] grp_base(input logic [GRP_W-1:0] g);
    logic [ENT_W-1:0] gx;
    gx = ENT_W'(g);
    return (gx << 1) + gx;
  endfunction

endpackage

`default_nettype wire

/* design/ksvm_lane.sv */
// ----------------------------------------------------------------------------
// ksvm_lane
// one velocity component: square, then v times squared speed in two halves
// ----------------------------------------------------------------------------
`default_nettype none

module ksvm_lane #(
  parameter int VEL_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic signed [VEL_BITS-1:0] vel,
  input  wire logic [((2*VEL_BITS+1) > 33 ? (2*VEL_BITS+1) : 33)-1:0] speed,
  output logic [2*VEL_BITS-2:0]           sq_early,
  output logic signed [VEL_BITS-1:0]      vel_o,
  output logic [2*VEL_BITS-2:0]           sq_o,
  output logic [ksvm_pkg::VAL_W-1:0]      cube_o
);
  import ksvm_pkg::*;

  localparam int SQ_W  = 2*VEL_BITS - 1;
  localparam int SP_W  = 2*VEL_BITS + 1;
  localparam int SPX_W = (SP_W > 33) ? SP_W : 33;
  localparam int HI_W  = SPX_W - 32;
  localparam int PL_W  = VEL_BITS + 33;
  localparam int PH_W  = VEL_BITS + HI_W + 1;

  logic signed [2*VEL_BITS-1:0] sq_full;
  logic signed [VEL_BITS-1:0]   v1_r, v2_r, v3_r, v4_r;
  logic [SQ_W-1:0]              sq1_r, sq2_r, sq3_r, sq4_r;
  logic signed [PL_W-1:0]       pl_r;
  logic signed [PH_W-1:0]       ph_r;
  logic [VAL_W-1:0]             ph_ext;
  logic [VAL_W-1:0]             cube_nxt;
  logic [VAL_W-1:0]             cube_r;

  assign sq_full = vel * vel;

  // speed split at bit 32 keeps each multiplier near 32 bits wide
  assign ph_ext   = VAL_W'(ph_r);
  assign cube_nxt = VAL_W'(pl_r) + {ph_ext[31:0], 32'd0};

  always_ff @(posedge clk) begin
    v1_r   <= vel;
    sq1_r  <= sq_full[SQ_W-1:0];
    v2_r   <= v1_r;
    sq2_r  <= sq1_r;
    pl_r   <= v2_r * $signed({1'b0, speed[31:0]});
    ph_r   <= v2_r * $signed({1'b0, speed[SPX_W-1:32]});
    v3_r   <= v2_r;
    sq3_r  <= sq2_r;
    cube_r <= cube_nxt;
    v4_r   <= v3_r;
    sq4_r  <= sq3_r;
  end

  assign sq_early = sq1_r;
  assign vel_o    = v4_r;
  assign sq_o     = sq4_r;
  assign cube_o   = cube_r;

endmodule

`default_nettype wire

/* design/ksvm_accum.sv */
// ----------------------------------------------------------------------------
// ksvm_accum
// merge stage: adds the three lanes into one group's sums, read-out mux
// ----------------------------------------------------------------------------
`default_nettype none

module ksvm_accum #(
  parameter int VEL_BITS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire ksvm_pkg::acc_ctl_t                           ctl,
  input  wire logic [ksvm_pkg::NUM_COMP-1:0][VEL_BITS-1:0]  vel,
  input  wire logic [ksvm_pkg::NUM_COMP-1:0][2*VEL_BITS-2:0] sq,
  input  wire logic [ksvm_pkg::NUM_COMP-1:0][ksvm_pkg::VAL_W-1:0] cube,
  input  wire logic [ksvm_pkg::GRP_W-1:0]                   rd_grp,
  input  wire logic [ksvm_pkg::MOM_W-1:0]                   rd_mom,
  output logic [ksvm_pkg::VAL_W-1:0]                        rd_val
);
  import ksvm_pkg::*;

  localparam int F_W   = VEL_BITS + COUNT_BITS;
  localparam int S_RAW = 2*VEL_BITS + COUNT_BITS - 1;
  localparam int S_W   = (S_RAW > VAL_W) ? VAL_W : S_RAW;

  logic signed [F_W-1:0] fs_r [NUM_ENTRIES];
  logic [S_W-1:0]        ss_r [NUM_ENTRIES];
  logic [VAL_W-1:0]      ts_r [NUM_ENTRIES];

  logic [ENT_W-1:0] wr_base;
  logic [ENT_W-1:0] rd_base;
  logic [ENT_W-1:0] rd_ent;
  logic [MOM_W-1:0] rd_off;

  assign wr_base = grp_base(ctl.grp);
  assign rd_base = grp_base(rd_grp);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        fs_r[e] <= '0;
        ss_r[e] <= '0;
        ts_r[e] <= '0;
      end
    end else if (ctl.add) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        fs_r[wr_base + ENT_W'(c)] <= fs_r[wr_base + ENT_W'(c)] + F_W'($signed(vel[c]));
        ss_r[wr_base + ENT_W'(c)] <= ss_r[wr_base + ENT_W'(c)] + S_W'(sq[c]);
        ts_r[wr_base + ENT_W'(c)] <= ts_r[wr_base + ENT_W'(c)] + cube[c];
      end
    end
  end

  // read-out select
  always_comb begin
    rd_off = '0;
    if (rd_mom >= MOM_THIRD_X) begin
      rd_off = rd_mom - MOM_THIRD_X;
    end else if (rd_mom >= MOM_SECOND_X) begin
      rd_off = rd_mom - MOM_SECOND_X;
    end else if (rd_mom >= MOM_FIRST_X) begin
      rd_off = rd_mom - MOM_FIRST_X;
    end
    rd_ent = rd_base + ENT_W'(rd_off[1:0]);

    if (rd_mom == MOM_TOTAL) begin
      rd_val = VAL_W'(ss_r[rd_base]) + VAL_W'(ss_r[rd_base + ENT_W'(1)])
             + VAL_W'(ss_r[rd_base + ENT_W'(2)]);
    end else if (rd_mom >= MOM_THIRD_X && rd_mom <= MOM_THIRD_Z) begin
      rd_val = ts_r[rd_ent];
    end else if (rd_mom >= MOM_SECOND_X && rd_mom <= MOM_SECOND_Z) begin
      rd_val = VAL_W'(ss_r[rd_ent]);
    end else if (rd_mom >= MOM_FIRST_X && rd_mom <= MOM_FIRST_Z) begin
      rd_val = VAL_W'(fs_r[rd_ent]);
    end else begin
      rd_val = '0;
    end
  end

endmodule

`default_nettype wire

/* design/kind_split_velocity_moments.sv */
// add item: accepted every cycle while in_stall is low, reaches the group sums through the lane pipeline
// finish item: waits for the lane pipeline to drain, then
//   emits 33 results, one per cycle while out_stall is low, in_stall held high
// lane pipeline stages: square, speed sum, split multiply, combine; then the merge
// reset: synchronous, clears counts, drop flags, sums and the output valid
// ----------------------------------------------------------------------------
// kind_split_velocity_moments
// per-group velocity moments (count, v, v^2, v*|v|^2, |v|^2) over three groups
// ----------------------------------------------------------------------------
`default_nettype none

module kind_split_velocity_moments #(
  parameter int COUNT_BITS = 16,
  parameter int VEL_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic [1:0]                    in_kind,
  input  wire logic signed [VEL_BITS-1:0]    in_vel_x,
  input  wire logic signed [VEL_BITS-1:0]    in_vel_y,
  input  wire logic signed [VEL_BITS-1:0]    in_vel_z,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ksvm_pkg::GRP_W-1:0]         out_group,
  output logic [ksvm_pkg::MOM_W-1:0]         out_moment_index,
  output logic signed [ksvm_pkg::VAL_W-1:0]  out_moment_value,
  output logic                               out_overflowed,
  output logic                               out_last
);
  import ksvm_pkg::*;

  localparam int SQ_W  = 2*VEL_BITS - 1;
  localparam int SP_W  = 2*VEL_BITS + 1;
  localparam int SPX_W = (SP_W > 33) ? SP_W : 33;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // per-group counts and drop flags live here so the limit is decided at accept
  logic [COUNT_BITS-1:0] cnt_r [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] drop_r;

  // valid and group travel alongside the lane data
  logic [PIPE_D-1:0] p_vld_r;
  logic [GRP_W-1:0]  p_grp_r [PIPE_D];

  logic [GRP_W-1:0] emit_g_r, emit_g_nxt;
  logic [MOM_W-1:0] emit_m_r, emit_m_nxt;

  logic              out_vld_r;
  logic [GRP_W-1:0]  out_grp_r;
  logic [MOM_W-1:0]  out_mom_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_ovf_r;
  logic              out_last_r;

  logic in_acc;
  logic add_item;
  logic launch;
  logic at_limit;
  logic out_free;
  logic emit_go;
  logic emit_last;

  logic [NUM_COMP-1:0][VEL_BITS-1:0] lane_vin;
  logic [NUM_COMP-1:0][SQ_W-1:0]     lane_sq1;
  logic [NUM_COMP-1:0][VEL_BITS-1:0] lane_v;
  logic [NUM_COMP-1:0][SQ_W-1:0]     lane_sq;
  logic [NUM_COMP-1:0][VAL_W-1:0]    lane_cube;
  logic [SPX_W-1:0]                  speed_r;

  acc_ctl_t         acc_ctl;
  logic [VAL_W-1:0] acc_val;

  // ---------------------------------------------------------------- handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign add_item  = in_acc && (in_mode == MODE_ADD) && (in_kind <= GRP_FULL);
  assign at_limit  = &cnt_r[in_kind[GRP_W-1:0]];
  assign launch    = add_item && !at_limit;

  assign out_free  = !out_vld_r || !out_stall;
  assign emit_go   = (state_r == ST_EMIT) && out_free;
  assign emit_last = (emit_g_r == GRP_FULL) && (emit_m_r == MOM_TOTAL);

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt  = state_r;
    emit_g_nxt = emit_g_r;
    emit_m_nxt = emit_m_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_FINISH) begin
          state_nxt  = ST_DRAIN;
          emit_g_nxt = GRP_POS;
          emit_m_nxt = MOM_COUNT;
        end
      end
      ST_DRAIN: begin
        // sums are final once no add is left in the lanes
        if (p_vld_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else if (emit_m_r == MOM_TOTAL) begin
            emit_g_nxt = emit_g_r + GRP_W'(1);
            emit_m_nxt = MOM_COUNT;
          end else begin
            emit_m_nxt = emit_m_r + MOM_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      p_vld_r   <= '0;
      out_vld_r <= 1'b0;
      drop_r    <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        cnt_r[g] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      p_vld_r <= {p_vld_r[PIPE_D-2:0], launch};
      if (emit_go) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (emit_go && emit_last) begin
        // whole run loaded: start the next accumulation from zero
        drop_r <= '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
          cnt_r[g] <= '0;
        end
      end else if (add_item) begin
        if (at_limit) begin
          drop_r[in_kind[GRP_W-1:0]] <= 1'b1;
        end else begin
          cnt_r[in_kind[GRP_W-1:0]] <= cnt_r[in_kind[GRP_W-1:0]] + COUNT_BITS'(1);
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    emit_g_r   <= emit_g_nxt;
    emit_m_r   <= emit_m_nxt;
    p_grp_r[0] <= in_kind[GRP_W-1:0];
    for (int s = 1; s < PIPE_D; s++) begin
      p_grp_r[s] <= p_grp_r[s-1];
    end
    // squared speed from the first lane stage, feeds the cube multiply
    speed_r <= SPX_W'(lane_sq1[0]) + SPX_W'(lane_sq1[1]) + SPX_W'(lane_sq1[2]);
    if (emit_go) begin
      out_grp_r  <= emit_g_r;
      out_mom_r  <= emit_m_r;
      out_val_r  <= (emit_m_r == MOM_COUNT) ? VAL_W'(cnt_r[emit_g_r]) : acc_val;
      out_ovf_r  <= drop_r[emit_g_r];
      out_last_r <= emit_last;
    end
  end

  // ------------------------------------------------------------------- lanes
  assign lane_vin[0] = in_vel_x;
  assign lane_vin[1] = in_vel_y;
  assign lane_vin[2] = in_vel_z;

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
    ksvm_lane #(
      .VEL_BITS (VEL_BITS)
    ) u_lane (
      .clk      (clk),
      .vel      ($signed(lane_vin[c])),
      .speed    (speed_r),
      .sq_early (lane_sq1[c]),
      .vel_o    (lane_v[c]),
      .sq_o     (lane_sq[c]),
      .cube_o   (lane_cube[c])
    );
  end

  // ------------------------------------------------------------------- merge
  always_comb begin
    acc_ctl.add = p_vld_r[PIPE_D-1];
    acc_ctl.grp = p_grp_r[PIPE_D-1];
    acc_ctl.clr = emit_go && emit_last;
  end

  ksvm_accum #(
    .VEL_BITS   (VEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .vel    (lane_v),
    .sq     (lane_sq),
    .cube   (lane_cube),
    .rd_grp (emit_g_r),
    .rd_mom (emit_m_r),
    .rd_val (acc_val)
  );

  // ----------------------------------------------------------------- outputs
  assign out_valid        = out_vld_r;
  assign out_group        = out_grp_r;
  assign out_moment_index = out_mom_r;
  assign out_moment_value = $signed(out_val_r);
  assign out_overflowed   = out_ovf_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

/* tb/sv/tb_kind_split_velocity_moments.sv */
// ----------------------------------------------------------------------------
// tb_kind_split_velocity_moments
// self-checking bench for the three-group velocity moment accumulator: particle
// items and finish items are driven over a valid/stall channel. A scoreboard
// keeps its own copy of counts, sums and drop flags, and predicts the 33
// moments of each finish. The result channel is checked field by field under
// random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_kind_split_velocity_moments;
  import ksvm_pkg::*;

  localparam int CNT_BITS       = 16;
  localparam int VEL_W          = 16;
  localparam int COUNT_LIMIT    = (1 << CNT_BITS) - 1;
  localparam int RANDOM_ITEMS   = 180;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * PIPE_D + 8;

  // kind code that names no group, ignored on add items
  localparam logic [GRP_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef logic [VAL_W-1:0] word_t;

  typedef struct {
    logic [GRP_W-1:0] group;
    logic [MOM_W-1:0] index;
    word_t            value;
    logic             overflowed;
    logic             last;
  } moment_t;

  // running per-group moments and the queue of moments still owed by the block
  class moment_book;
    moment_t pending[$];
    word_t   count[NUM_GROUPS];
    word_t   sum_v[NUM_ENTRIES];
    word_t   sum_vv[NUM_ENTRIES];
    word_t   sum_vss[NUM_ENTRIES];
    bit      dropped[NUM_GROUPS];
    int      errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int g = 0; g < NUM_GROUPS; g++) begin
        count[g]   = '0;
        dropped[g] = 1'b0;
      end
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        sum_v[e]   = '0;
        sum_vv[e]  = '0;
        sum_vss[e] = '0;
      end
    endfunction

    function word_t widen(logic [VEL_W-1:0] raw);
      return {{(VAL_W-VEL_W){raw[VEL_W-1]}}, raw};
    endfunction

    // accepted input item: update the sums or queue the moments of a finish
    function void note_particle(logic mode, logic [GRP_W-1:0] kind,
                                logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy,
                                logic [VEL_W-1:0] vz);
      word_t   v[NUM_COMP];
      word_t   speed2;
      moment_t m;
      int      g;
      int      e;
      if (mode == MODE_ADD) begin
        if (kind == KIND_UNKNOWN) return;
        g = int'(kind);
        if (count[g] >= word_t'(COUNT_LIMIT)) begin
          dropped[g] = 1'b1;
          return;
        end
        count[g] += 1;
        v[0] = widen(vx);
        v[1] = widen(vy);
        v[2] = widen(vz);
        speed2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        for (int c = 0; c < NUM_COMP; c++) begin
          e = g * NUM_COMP + c;
          sum_v[e]   += v[c];
          sum_vv[e]  += v[c] * v[c];
          sum_vss[e] += v[c] * speed2;
        end
      end else begin
        for (g = 0; g < NUM_GROUPS; g++) begin
          e = g * NUM_COMP;
          for (int idx = 0; idx < NUM_MOMENTS; idx++) begin
            m.group      = GRP_W'(g);
            m.index      = MOM_W'(idx);
            m.overflowed = dropped[g];
            m.last       = (g == NUM_GROUPS - 1) && (idx == NUM_MOMENTS - 1);
            if (m.index == MOM_COUNT)
              m.value = count[g];
            else if (m.index <= MOM_FIRST_Z)
              m.value = sum_v[e + int'(m.index - MOM_FIRST_X)];
            else if (m.index <= MOM_SECOND_Z)
              m.value = sum_vv[e + int'(m.index - MOM_SECOND_X)];
            else if (m.index <= MOM_THIRD_Z)
              m.value = sum_vss[e + int'(m.index - MOM_THIRD_X)];
            else
              m.value = sum_vv[e] + sum_vv[e + 1] + sum_vv[e + 2];
            pending = {pending, m};
          end
        end
        clear();
      end
    endfunction

    function void report(string what, word_t want, word_t got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_moment(logic [GRP_W-1:0] group, logic [MOM_W-1:0] index,
                               word_t value, logic overflowed, logic last);
      moment_t want;
      if (pending.size() == 0) begin
        errors++;
        $display({"%0t: result with nothing expected, expected none, ",
                  "actual group %0d index %0d value %0h"},
                 $time, group, index, value);
        return;
      end
      want = pending.pop_front();
      if (want.group !== group) report("group", word_t'(want.group), word_t'(group));
      if (want.index !== index) report("moment_index", word_t'(want.index), word_t'(index));
      if (want.value !== value) report("moment_value", want.value, value);
      if (want.overflowed !== overflowed)
        report("overflowed", word_t'(want.overflowed), word_t'(overflowed));
      if (want.last !== last) report("last", word_t'(want.last), word_t'(last));
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction
  endclass

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // input channel, known from time zero
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_mode  = MODE_ADD;
  logic [1:0]              in_kind  = GRP_POS;
  logic signed [VEL_W-1:0] in_vel_x = '0;
  logic signed [VEL_W-1:0] in_vel_y = '0;
  logic signed [VEL_W-1:0] in_vel_z = '0;

  // result channel
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [GRP_W-1:0]        out_group;
  logic [MOM_W-1:0]        out_moment_index;
  logic signed [VAL_W-1:0] out_moment_value;
  logic                    out_overflowed;
  logic                    out_last;

  // idling knobs, hold-off request and watchdog
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_start     = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;

  moment_book book;

  kind_split_velocity_moments #(
    .COUNT_BITS(CNT_BITS),
    .VEL_BITS  (VEL_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_kind         (in_kind),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_group       (out_group),
    .out_moment_index(out_moment_index),
    .out_moment_value(out_moment_value),
    .out_overflowed  (out_overflowed),
    .out_last        (out_last)
  );

  // receiver: values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_moment(out_group, out_moment_index, out_moment_value,
                        out_overflowed, out_last);
    // long hold-off counted here, random stall otherwise
    if (hold_start)
      hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one item, hold it until taken, then idle cycle by cycle at random
  task automatic offer(input logic mode, input logic [1:0] kind,
                       input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                       input logic [VEL_W-1:0] vz);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_kind  <= kind;
    in_vel_x <= vx;
    in_vel_y <= vy;
    in_vel_z <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_particle(mode, kind, vx, vy, vz);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // lower valid after the last item of a burst
  task automatic rest();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (!book.idle()) @(posedge clk);
  endtask

  // velocity with a bias toward the extremes
  function automatic logic [VEL_W-1:0] rand_vel();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return VEL_W'($urandom);
    endcase
  endfunction

  initial begin
    int          done;
    int          r;
    logic        mode;
    logic [1:0]  kind;
    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes per group, unknown kind, finish with junk, empty finish
    offer(MODE_ADD, GRP_POS, 16'h0000, 16'h0000, 16'h0000);
    offer(MODE_ADD, GRP_POS, 16'h7fff, 16'h7fff, 16'h7fff);
    offer(MODE_ADD, GRP_POS, 16'h8000, 16'h8000, 16'h8000);
    offer(MODE_ADD, GRP_NEG, 16'h8000, 16'h7fff, 16'hffff);
    offer(MODE_ADD, GRP_NEG, 16'h0001, 16'h8000, 16'h7fff);
    offer(MODE_ADD, GRP_FULL, 16'h7fff, 16'h0000, 16'h8000);
    offer(MODE_ADD, GRP_FULL, 16'hffff, 16'hffff, 16'hffff);
    offer(MODE_ADD, KIND_UNKNOWN, 16'h7fff, 16'h8000, 16'h7fff);
    offer(MODE_FINISH, KIND_UNKNOWN, 16'h1234, 16'h8000, 16'hffff);
    offer(MODE_FINISH, GRP_POS, 16'h0000, 16'h0000, 16'h0000);
    offer(MODE_ADD, GRP_FULL, 16'h5555, 16'haaaa, 16'h5a5a);
    offer(MODE_ADD, GRP_NEG, 16'haaaa, 16'h5555, 16'ha5a5);
    offer(MODE_FINISH, GRP_FULL, 16'hffff, 16'hffff, 16'hffff);
    rest();
    drain();

    // random: four idling phases, each closed by a finish
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 64; end
        default: begin send_idle_pct = 21; recv_stall_pct <= 21; end
      endcase
      done = 0;
      while (done < RANDOM_ITEMS / 4) begin
        mode = ($urandom_range(15) == 0) ? MODE_FINISH : MODE_ADD;
        r    = $urandom_range(15);
        kind = (r == 15) ? KIND_UNKNOWN : 2'(r % NUM_GROUPS);
        offer(mode, kind, rand_vel(), rand_vel(), rand_vel());
        // ignored items do not count toward the phase length
        if (!(mode == MODE_ADD && kind == KIND_UNKNOWN))
          done++;
      end
      offer(MODE_FINISH, 2'($urandom_range(3)), rand_vel(), rand_vel(), rand_vel());
    end
    rest();
    drain();

    // pressure: receiver holds off while adds and finishes keep coming
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int k = 0; k < 20; k++)
      offer(MODE_ADD, 2'($urandom_range(2)), rand_vel(), rand_vel(), rand_vel());
    offer(MODE_FINISH, GRP_POS, rand_vel(), rand_vel(), rand_vel());
    for (int k = 0; k < 20; k++)
      offer(MODE_ADD, 2'($urandom_range(2)), rand_vel(), rand_vel(), rand_vel());
    offer(MODE_FINISH, GRP_NEG, rand_vel(), rand_vel(), rand_vel());
    rest();
    drain();

    // let any stray result surface before deciding
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.idle())
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
